### hdl/pbw_pkg.sv
// shared types, codes and helpers for the protobuf wire encoder
`default_nettype none

package pbw_pkg;

    localparam int BUF_BYTES = 65536;
    localparam int OFF_W     = 17;
    localparam int ADDR_W    = 16;
    localparam int MARK_W    = 20;

    // request codes
    localparam logic [2:0] REQ_VARINT = 3'd0;
    localparam logic [2:0] REQ_BYTES  = 3'd1;
    localparam logic [2:0] REQ_RAW    = 3'd2;
    localparam logic [2:0] REQ_START  = 3'd3;
    localparam logic [2:0] REQ_COMMIT = 3'd4;

    // wire types placed in the tag
    localparam logic [2:0] WT_VARINT = 3'd0;
    localparam logic [2:0] WT_LEN    = 3'd2;

    // error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_FULL     = 2'd1;
    localparam logic [1:0] ERR_TOO_LONG = 2'd2;
    localparam logic [1:0] ERR_BAD_MARK = 2'd3;

    // one classified request: up to two byte runs written from addr upward
    typedef struct packed {
        logic [31:0]       a;
        logic [2:0]        na;
        logic [63:0]       b;
        logic [3:0]        nb;
        logic [ADDR_W-1:0] addr;
        logic [MARK_W-1:0] mark;
        logic [OFF_W-1:0]  offset;
        logic [1:0]        err;
    } cmd_t;

    // number of 7-bit groups needed to hold v, at least one
    function automatic logic [3:0] vsize(input logic [63:0] v);
        logic [3:0] n;
        n = 4'd1;
        for (int g = 1; g < 10; g++)
        begin
            if ((v >> (7 * g)) != 64'd0)
            begin
                n = 4'(g + 1);
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

### hdl/pbw_front.sv
// front end: accepts requests, checks them against the write offset, builds commands
`default_nettype none

module pbw_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [2:0]                  req_type,
    input  wire logic [28:0]                 field_number,
    input  wire logic [63:0]                 value,
    input  wire logic [7:0]                  data_byte,
    input  wire logic [2:0]                  reserve_bytes,
    input  wire logic [pbw_pkg::MARK_W-1:0]  mark_in,
    output logic                             cmd_push,
    output pbw_pkg::cmd_t                    cmd,
    input  wire logic                        cmd_full
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CALC  = 2'd1;
    localparam logic [1:0] ST_CHECK = 2'd2;

    logic [1:0]                    state_reg, state_next;
    logic [pbw_pkg::OFF_W-1:0]     offset_reg, offset_next;

    // captured request
    logic [2:0]                    req_type_reg;
    logic [28:0]                   field_number_reg;
    logic [63:0]                   value_reg;
    logic [7:0]                    data_byte_reg;
    logic [2:0]                    reserve_reg;
    logic [pbw_pkg::MARK_W-1:0]    mark_in_reg;

    // first-stage results
    logic [31:0]                   tag_reg;
    logic [2:0]                    tag_n_reg;
    logic [3:0]                    val_n_reg;
    logic [pbw_pkg::OFF_W-1:0]     room_reg;
    logic                          bad_mark_reg;
    logic [pbw_pkg::OFF_W-1:0]     len_reg;
    logic [pbw_pkg::OFF_W-1:0]     st_reg;
    logic [2:0]                    cnt_reg;

    logic                          accept;
    logic [31:0]                   tag_c;
    logic [2:0]                    tag_n_c;
    logic [2:0]                    cnt_c;
    logic [pbw_pkg::OFF_W-1:0]     st_c;
    logic [pbw_pkg::OFF_W:0]       st_end_c;

    logic [4:0]                    need_v;
    logic [4:0]                    need_m;
    logic [pbw_pkg::OFF_W-1:0]     spare;
    logic                          over_v;
    logic [3:0]                    len_n;
    logic [pbw_pkg::OFF_W-1:0]     off_tag;

    assign full   = (state_reg != ST_IDLE);
    assign accept = push && !full;

    always_comb
    begin
        tag_c    = {field_number_reg,
                    (req_type_reg == pbw_pkg::REQ_VARINT) ? pbw_pkg::WT_VARINT
                                                          : pbw_pkg::WT_LEN};
        tag_n_c  = 3'(pbw_pkg::vsize({32'd0, tag_c}));
        cnt_c    = mark_in_reg[2:0];
        st_c     = mark_in_reg[pbw_pkg::MARK_W-1:3];
        st_end_c = {1'b0, st_c} + (pbw_pkg::OFF_W + 1)'(cnt_c);
    end

    always_comb
    begin
        need_v  = 5'(tag_n_reg) + 5'(val_n_reg);
        need_m  = 5'(tag_n_reg) + 5'(reserve_reg);
        spare   = room_reg - pbw_pkg::OFF_W'(need_v);
        over_v  = (pbw_pkg::OFF_W'(need_v) > room_reg)
               || ((req_type_reg == pbw_pkg::REQ_BYTES)
                   && (value_reg > {47'd0, spare}));
        len_n   = pbw_pkg::vsize({47'd0, len_reg});
        off_tag = offset_reg + pbw_pkg::OFF_W'(tag_n_reg);

        cmd        = '0;
        cmd.addr   = offset_reg[pbw_pkg::ADDR_W-1:0];
        cmd.offset = offset_reg;
        cmd.err    = pbw_pkg::ERR_NONE;
        unique case (req_type_reg)
            pbw_pkg::REQ_VARINT, pbw_pkg::REQ_BYTES:
            begin
                if (over_v)
                begin
                    cmd.err = pbw_pkg::ERR_FULL;
                end
                else
                begin
                    cmd.a      = tag_reg;
                    cmd.na     = tag_n_reg;
                    cmd.b      = value_reg;
                    cmd.nb     = val_n_reg;
                    cmd.offset = offset_reg + pbw_pkg::OFF_W'(need_v);
                end
            end
            pbw_pkg::REQ_RAW:
            begin
                if (room_reg == '0)
                begin
                    cmd.err = pbw_pkg::ERR_FULL;
                end
                else
                begin
                    cmd.a      = {24'd0, data_byte_reg};
                    cmd.na     = 3'd1;
                    cmd.offset = offset_reg + pbw_pkg::OFF_W'(1);
                end
            end
            pbw_pkg::REQ_START:
            begin
                if (reserve_reg == 3'd0)
                begin
                    cmd.err = pbw_pkg::ERR_TOO_LONG;
                end
                else if (pbw_pkg::OFF_W'(need_m) > room_reg)
                begin
                    cmd.err = pbw_pkg::ERR_FULL;
                end
                else
                begin
                    cmd.a      = tag_reg;
                    cmd.na     = tag_n_reg;
                    cmd.mark   = {off_tag, reserve_reg};
                    cmd.offset = off_tag + pbw_pkg::OFF_W'(reserve_reg);
                end
            end
            pbw_pkg::REQ_COMMIT:
            begin
                if (bad_mark_reg)
                begin
                    cmd.err = pbw_pkg::ERR_BAD_MARK;
                end
                else if (len_n > 4'(cnt_reg))
                begin
                    cmd.err = pbw_pkg::ERR_TOO_LONG;
                end
                else
                begin
                    // padded length: continuation on all reserved bytes but the last
                    cmd.a    = {15'd0, len_reg};
                    cmd.na   = cnt_reg;
                    cmd.addr = st_reg[pbw_pkg::ADDR_W-1:0];
                end
            end
            default:
            begin
                cmd.err = pbw_pkg::ERR_NONE;
            end
        endcase
    end

    assign cmd_push = (state_reg == ST_CHECK) && !cmd_full;

    always_comb
    begin
        state_next  = state_reg;
        offset_next = offset_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (!cmd_full)
                begin
                    state_next  = ST_IDLE;
                    offset_next = cmd.offset;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            offset_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            offset_reg <= offset_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_type_reg     <= req_type;
            field_number_reg <= field_number;
            value_reg        <= value;
            data_byte_reg    <= data_byte;
            reserve_reg      <= reserve_bytes;
            mark_in_reg      <= mark_in;
        end
        if (state_reg == ST_CALC)
        begin
            tag_reg      <= tag_c;
            tag_n_reg    <= tag_n_c;
            val_n_reg    <= pbw_pkg::vsize(value_reg);
            room_reg     <= pbw_pkg::OFF_W'(pbw_pkg::BUF_BYTES) - offset_reg;
            bad_mark_reg <= (cnt_c == 3'd0) || (st_end_c > {1'b0, offset_reg});
            len_reg      <= pbw_pkg::OFF_W'({1'b0, offset_reg} - st_end_c);
            st_reg       <= st_c;
            cnt_reg      <= cnt_c;
        end
    end

endmodule

`default_nettype wire

### hdl/pbw_queue.sv
// two-entry command queue between the front end and the byte writer
`default_nettype none

module pbw_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire pbw_pkg::cmd_t wr_data,
    output logic               q_full,
    input  wire logic          rd_en,
    output pbw_pkg::cmd_t      rd_data,
    output logic               q_empty
);

    pbw_pkg::cmd_t mem_reg [2];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    count_reg, count_next;
    logic          do_wr, do_rd;

    assign q_full  = (count_reg == 2'd2);
    assign q_empty = (count_reg == 2'd0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

### hdl/pbw_back.sv
// byte writer: command into byte writes, one per cycle unless the output register stalls
`default_nettype none

module pbw_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire pbw_pkg::cmd_t               cmd,
    input  wire logic                        cmd_empty,
    output logic                             cmd_pop,
    output logic                             empty,
    input  wire logic                        pop,
    output logic                             wr_valid,
    output logic [pbw_pkg::ADDR_W-1:0]       wr_addr,
    output logic [7:0]                       wr_byte,
    output logic                             last,
    output logic [pbw_pkg::MARK_W-1:0]       mark_out,
    output logic [pbw_pkg::OFF_W-1:0]        offset_out,
    output logic [1:0]                       error
);

    logic                          busy_reg;
    logic [31:0]                   sa_reg;
    logic [2:0]                    na_reg;
    logic [63:0]                   sb_reg;
    logic [3:0]                    nb_reg;
    logic [pbw_pkg::ADDR_W-1:0]    addr_reg;
    logic [pbw_pkg::MARK_W-1:0]    mark_reg;
    logic [pbw_pkg::OFF_W-1:0]     off_reg;
    logic [1:0]                    err_reg;

    logic                          ov_reg;
    logic                          wr_valid_reg;
    logic [pbw_pkg::ADDR_W-1:0]    wr_addr_reg;
    logic [7:0]                    wr_byte_reg;
    logic                          last_reg;
    logic [pbw_pkg::MARK_W-1:0]    mark_out_reg;
    logic [pbw_pkg::OFF_W-1:0]     offset_out_reg;
    logic [1:0]                    error_reg;

    logic                          step;
    logic                          use_a, use_b, write_c, last_c;
    logic [7:0]                    byte_c;

    assign cmd_pop = !busy_reg && !cmd_empty;
    assign step    = busy_reg && (!ov_reg || pop);

    always_comb
    begin
        use_a   = (na_reg != 3'd0);
        use_b   = !use_a && (nb_reg != 4'd0);
        write_c = use_a || use_b;
        byte_c  = 8'd0;
        if (use_a)
        begin
            byte_c = (na_reg > 3'd1) ? {1'b1, sa_reg[6:0]} : sa_reg[7:0];
        end
        else if (use_b)
        begin
            byte_c = (nb_reg > 4'd1) ? {1'b1, sb_reg[6:0]} : sb_reg[7:0];
        end
        // a command with no bytes still gives one item that carries the status
        last_c = use_a ? ((na_reg == 3'd1) && (nb_reg == 4'd0)) : (nb_reg <= 4'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (cmd_pop)
            begin
                busy_reg <= 1'b1;
            end
            else if (step && last_c)
            begin
                busy_reg <= 1'b0;
            end
            if (step)
            begin
                ov_reg <= 1'b1;
            end
            else if (pop)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            sa_reg   <= cmd.a;
            na_reg   <= cmd.na;
            sb_reg   <= cmd.b;
            nb_reg   <= cmd.nb;
            addr_reg <= cmd.addr;
            mark_reg <= cmd.mark;
            off_reg  <= cmd.offset;
            err_reg  <= cmd.err;
        end
        else if (step)
        begin
            if (use_a)
            begin
                sa_reg <= sa_reg >> 7;
                na_reg <= na_reg - 3'd1;
            end
            else if (use_b)
            begin
                sb_reg <= sb_reg >> 7;
                nb_reg <= nb_reg - 4'd1;
            end
            if (write_c)
            begin
                addr_reg <= addr_reg + pbw_pkg::ADDR_W'(1);
            end
        end
        if (step)
        begin
            wr_valid_reg   <= write_c;
            wr_addr_reg    <= write_c ? addr_reg : '0;
            wr_byte_reg    <= byte_c;
            last_reg       <= last_c;
            mark_out_reg   <= mark_reg;
            offset_out_reg <= off_reg;
            error_reg      <= err_reg;
        end
    end

    assign empty      = !ov_reg;
    assign wr_valid   = wr_valid_reg;
    assign wr_addr    = wr_addr_reg;
    assign wr_byte    = wr_byte_reg;
    assign last       = last_reg;
    assign mark_out   = mark_out_reg;
    assign offset_out = offset_out_reg;
    assign error      = error_reg;

endmodule

`default_nettype wire

### hdl/protobuf_wire_encoder.sv
// top level of the protobuf wire encoder: front end, command queue, byte writer
//
//  channel   direction  handshake          payload
//  request   in         push / full        req_type field_number value data_byte
//                                          reserve_bytes mark_in
//  result    out        empty / pop        wr_valid wr_addr wr_byte last mark_out
//                                          offset_out error
//
// the front end works on one request at a time in three steps (capture, size and bounds, command build)
// the byte writer loads a command, then gives one byte per cycle unless the output stalls (at least 1 item)
// the front end can build the next command while the writer is still emitting the last one
// reset clears the write offset and the queue and empties the output register; no clearing pass
// pop held low stalls the writer, then the two-entry queue, then full goes high
`default_nettype none

module protobuf_wire_encoder (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [2:0]                  req_type,
    input  wire logic [28:0]                 field_number,
    input  wire logic [63:0]                 value,
    input  wire logic [7:0]                  data_byte,
    input  wire logic [2:0]                  reserve_bytes,
    input  wire logic [pbw_pkg::MARK_W-1:0]  mark_in,
    output logic                             empty,
    input  wire logic                        pop,
    output logic                             wr_valid,
    output logic [pbw_pkg::ADDR_W-1:0]       wr_addr,
    output logic [7:0]                       wr_byte,
    output logic                             last,
    output logic [pbw_pkg::MARK_W-1:0]       mark_out,
    output logic [pbw_pkg::OFF_W-1:0]        offset_out,
    output logic [1:0]                       error
);

    pbw_pkg::cmd_t front_cmd, back_cmd;
    logic          cmd_push, cmd_full, cmd_pop, cmd_empty;

    pbw_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .req_type      (req_type),
        .field_number  (field_number),
        .value         (value),
        .data_byte     (data_byte),
        .reserve_bytes (reserve_bytes),
        .mark_in       (mark_in),
        .cmd_push      (cmd_push),
        .cmd           (front_cmd),
        .cmd_full      (cmd_full)
    );

    pbw_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (front_cmd),
        .q_full  (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (back_cmd),
        .q_empty (cmd_empty)
    );

    pbw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (back_cmd),
        .cmd_empty  (cmd_empty),
        .cmd_pop    (cmd_pop),
        .empty      (empty),
        .pop        (pop),
        .wr_valid   (wr_valid),
        .wr_addr    (wr_addr),
        .wr_byte    (wr_byte),
        .last       (last),
        .mark_out   (mark_out),
        .offset_out (offset_out),
        .error      (error)
    );

endmodule

`default_nettype wire

### hdl/pbw_checker.sv
// port-level checks for the protobuf wire encoder, bound to the top level
`default_nettype none

module pbw_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        empty,
    input  wire logic                        pop,
    input  wire logic                        wr_valid,
    input  wire logic [pbw_pkg::ADDR_W-1:0]  wr_addr,
    input  wire logic [7:0]                  wr_byte,
    input  wire logic                        last,
    input  wire logic [pbw_pkg::MARK_W-1:0]  mark_out,
    input  wire logic [pbw_pkg::OFF_W-1:0]   offset_out,
    input  wire logic [1:0]                  error
);

    // a waiting item holds until it is taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(wr_addr) && $stable(wr_byte)
                              && $stable(last) && $stable(offset_out)))
        else $error("waiting item changed before pop");

    // a rejected request is a single item with no write
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (error != pbw_pkg::ERR_NONE)) |-> (!wr_valid && last))
        else $error("rejected request wrote a byte or was not last");

    // an item without a write always ends its request
    a_nowrite_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !wr_valid) |-> last)
        else $error("item without a write was not last");

    // a rejected request carries no mark (only a successful start does)
    a_err_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (error != pbw_pkg::ERR_NONE)) |-> (mark_out == '0))
        else $error("rejected request carried a mark");

endmodule

bind protobuf_wire_encoder pbw_checker u_pbw_checker (.*);

`default_nettype wire

### verif/tb_protobuf_wire_encoder.sv
`timescale 1ns / 1ps
// testbench for protobuf_wire_encoder: directed rows and random field streams under idling phases

module tb_protobuf_wire_encoder;

    localparam logic [28:0] FN_MAX      = '1;
    localparam logic [2:0]  REQ_NONE_LO = 3'd5;
    localparam logic [2:0]  REQ_NONE_HI = 3'd7;
    localparam int          ITEMS_PER_PHASE = 68;

    typedef enum logic [1:0] {MK_LIT, MK_LAST, MK_HERE} mark_src_e;
    typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

    typedef struct {
        logic [2:0]                 kind;
        logic [28:0]                fnum;
        logic [63:0]                val;
        logic [7:0]                 dbyte;
        logic [2:0]                 rsv;
        logic [pbw_pkg::MARK_W-1:0] mark;
    } wire_req_t;

    typedef struct {
        logic                       wv;
        logic [pbw_pkg::ADDR_W-1:0] addr;
        logic [7:0]                 data;
        logic                       fin;
        logic [pbw_pkg::MARK_W-1:0] mark;
        logic [pbw_pkg::OFF_W-1:0]  offset;
        logic [1:0]                 err;
    } buf_write_t;

    typedef struct {
        wire_req_t  req;
        mark_src_e  msrc;
        bit         typed;
        logic [1:0] err;
    } stim_row_t;

    logic                       clk           = 1'b0;
    logic                       rst_n         = 1'b0;
    logic                       push          = 1'b0;
    logic                       pop           = 1'b0;
    logic [2:0]                 req_type      = '0;
    logic [28:0]                field_number  = '0;
    logic [63:0]                value         = '0;
    logic [7:0]                 data_byte     = '0;
    logic [2:0]                 reserve_bytes = '0;
    logic [pbw_pkg::MARK_W-1:0] mark_in       = '0;
    logic                       full;
    logic                       empty;
    logic                       wr_valid;
    logic [pbw_pkg::ADDR_W-1:0] wr_addr;
    logic [7:0]                 wr_byte;
    logic                       last;
    logic [pbw_pkg::MARK_W-1:0] mark_out;
    logic [pbw_pkg::OFF_W-1:0]  offset_out;
    logic [1:0]                 error;

    // encoder state as the testbench sees it
    logic [pbw_pkg::OFF_W-1:0]  buf_offset = '0;
    buf_write_t                 due_writes[$];
    logic [pbw_pkg::MARK_W-1:0] open_marks[$];
    logic [pbw_pkg::ADDR_W-1:0] run_addr[$];
    logic [7:0]                 run_data[$];
    stim_row_t                  stim_rows[$];

    idle_mode_e          idle_mode = IDLE_NONE;
    int                  items_sent = 0;
    int                  writes_checked = 0;
    int                  mismatches = 0;
    int                  err_seen[4] = '{0, 0, 0, 0};

    protobuf_wire_encoder dut (.*);

    always #5 clk = ~clk;

    function automatic bit coin(input int unsigned pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic bit sender_idles();
        case (idle_mode)
            IDLE_SEND: return coin(55);
            IDLE_BOTH: return coin(15);
            default:   return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (idle_mode)
            IDLE_RECV: return coin(55);
            IDLE_BOTH: return coin(15);
            default:   return 1'b0;
        endcase
    endfunction

    // random value of random bit length, 1 to maxw bits
    function automatic logic [63:0] rand_bits(input int unsigned maxw);
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v >> (64 - $urandom_range(maxw, 1));
    endfunction

    function automatic wire_req_t junk_req();
        wire_req_t r;
        r.kind  = 3'($urandom_range(7));
        r.fnum  = 29'(rand_bits(29));
        r.val   = rand_bits(64);
        r.dbyte = 8'($urandom);
        r.rsv   = 3'($urandom_range(7));
        r.mark  = pbw_pkg::MARK_W'($urandom);
        return r;
    endfunction

    function automatic logic [28:0] pick_fnum();
        return coin(50) ? 29'($urandom_range(15, 1)) : 29'(rand_bits(29));
    endfunction

    function automatic int unsigned groups7(input logic [63:0] v);
        int unsigned n;
        n = 1;
        while ((v >> 7) != 64'd0)
        begin
            v = v >> 7;
            n++;
        end
        return n;
    endfunction

    task automatic emit_byte(inout logic [63:0] at, input logic [7:0] data);
        run_addr.push_back(at[pbw_pkg::ADDR_W-1:0]);
        run_data.push_back(data);
        at = at + 64'd1;
    endtask

    task automatic emit_varint(inout logic [63:0] at, input logic [63:0] v);
        while ((v >> 7) != 64'd0)
        begin
            emit_byte(at, {1'b1, v[6:0]});
            v = v >> 7;
        end
        emit_byte(at, {1'b0, v[6:0]});
    endtask

    // turns one accepted request into the buffer writes it must produce
    task automatic encode_request(input wire_req_t r);
        logic [63:0]                off;
        logic [63:0]                room;
        logic [63:0]                tag;
        logic [63:0]                need;
        logic [63:0]                extra;
        logic [63:0]                cnt;
        logic [63:0]                st;
        logic [63:0]                len;
        logic [63:0]                pos;
        logic [2:0]                 wt;
        logic [pbw_pkg::MARK_W-1:0] mk;
        logic [1:0]                 err;
        bit                         wrote;
        int                         n;
        int                         i;
        buf_write_t                 w;
        off  = 64'(buf_offset);
        room = (off <= 64'(pbw_pkg::BUF_BYTES)) ? 64'(pbw_pkg::BUF_BYTES) - off : 64'd0;
        mk   = '0;
        err  = pbw_pkg::ERR_NONE;
        run_addr.delete();
        run_data.delete();
        case (r.kind)
            pbw_pkg::REQ_VARINT, pbw_pkg::REQ_BYTES:
            begin
                wt    = (r.kind == pbw_pkg::REQ_VARINT) ? pbw_pkg::WT_VARINT
                                                        : pbw_pkg::WT_LEN;
                tag   = 64'({r.fnum, wt});
                need  = 64'(groups7(tag) + groups7(r.val));
                extra = (r.kind == pbw_pkg::REQ_BYTES) ? r.val : 64'd0;
                // header plus announced payload has to fit
                if (need > room || extra > room - need)
                begin
                    err = pbw_pkg::ERR_FULL;
                end
                else
                begin
                    emit_varint(off, tag);
                    emit_varint(off, r.val);
                end
            end
            pbw_pkg::REQ_RAW:
            begin
                if (room == 64'd0)
                begin
                    err = pbw_pkg::ERR_FULL;
                end
                else
                begin
                    emit_byte(off, r.dbyte);
                end
            end
            pbw_pkg::REQ_START:
            begin
                tag  = 64'({r.fnum, pbw_pkg::WT_LEN});
                need = 64'(groups7(tag)) + 64'(r.rsv);
                if (r.rsv == 3'd0)
                begin
                    err = pbw_pkg::ERR_TOO_LONG;
                end
                else if (need > room)
                begin
                    err = pbw_pkg::ERR_FULL;
                end
                else
                begin
                    emit_varint(off, tag);
                    mk  = pbw_pkg::MARK_W'({off, r.rsv});
                    off = off + 64'(r.rsv);
                    open_marks.push_back(mk);
                end
            end
            pbw_pkg::REQ_COMMIT:
            begin
                cnt = 64'(r.mark[2:0]);
                st  = 64'(r.mark[pbw_pkg::MARK_W-1:3]);
                if (cnt == 64'd0 || st + cnt > off)
                begin
                    err = pbw_pkg::ERR_BAD_MARK;
                end
                else
                begin
                    len = off - st - cnt;
                    if (64'(groups7(len)) > cnt)
                    begin
                        err = pbw_pkg::ERR_TOO_LONG;
                    end
                    else
                    begin
                        // padded varint: continuation bit on all but the last reserved byte
                        pos = st;
                        while (pos + 64'd1 < st + cnt)
                        begin
                            emit_byte(pos, {1'b1, len[6:0]});
                            len = len >> 7;
                        end
                        emit_byte(pos, {1'b0, len[6:0]});
                    end
                end
            end
            default:
            begin
            end
        endcase
        wrote = run_addr.size() != 0;
        if (!wrote)
        begin
            run_addr.push_back('0);
            run_data.push_back('0);
        end
        n = run_addr.size();
        for (i = 0; i < n; i++)
        begin
            w = '{wrote, run_addr[i], run_data[i], i == n - 1, mk,
                  off[pbw_pkg::OFF_W-1:0], err};
            due_writes.push_back(w);
        end
        buf_offset = off[pbw_pkg::OFF_W-1:0];
    endtask

    task automatic send(input wire_req_t r, input bit typed, input logic [1:0] err);
        buf_write_t w;
        while (sender_idles())
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push          <= 1'b1;
        req_type      <= r.kind;
        field_number  <= r.fnum;
        value         <= r.val;
        data_byte     <= r.dbyte;
        reserve_bytes <= r.rsv;
        mark_in       <= r.mark;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        items_sent++;
        if (typed)
        begin
            // rejected or ignored: one empty result, offset unchanged
            w = '{1'b0, '0, '0, 1'b1, '0, buf_offset, err};
            due_writes.push_back(w);
        end
        else
        begin
            encode_request(r);
        end
    endtask

    task automatic add_row(input logic [2:0] kind, input logic [28:0] fnum,
                           input logic [63:0] val, input logic [7:0] dbyte,
                           input logic [2:0] rsv, input logic [pbw_pkg::MARK_W-1:0] mark,
                           input mark_src_e msrc, input bit typed, input logic [1:0] err);
        stim_row_t row;
        row.req  = '{kind, fnum, val, dbyte, rsv, mark};
        row.msrc = msrc;
        row.typed = typed;
        row.err  = err;
        stim_rows.push_back(row);
    endtask

    task automatic walk_rows();
        wire_req_t r;
        foreach (stim_rows[k])
        begin
            r = stim_rows[k].req;
            case (stim_rows[k].msrc)
                MK_LAST:
                begin
                    if (open_marks.size() != 0)
                    begin
                        r.mark = open_marks.pop_back();
                    end
                end
                MK_HERE: r.mark = pbw_pkg::MARK_W'({buf_offset, r.rsv});
                default: ;
            endcase
            send(r, stim_rows[k].typed, stim_rows[k].err);
        end
        stim_rows.delete();
    endtask

    task automatic random_step();
        wire_req_t   r;
        int unsigned pick;
        int unsigned n;
        r    = junk_req();
        pick = $urandom_range(99);
        if (pick < 25)
        begin
            r.kind = pbw_pkg::REQ_VARINT;
            r.fnum = pick_fnum();
            send(r, 1'b0, pbw_pkg::ERR_NONE);
        end
        else if (pick < 40)
        begin
            // length-delimited field followed by its payload bytes
            r.kind = pbw_pkg::REQ_BYTES;
            r.fnum = pick_fnum();
            n      = coin(8) ? $urandom_range(200, 100) : $urandom_range(12);
            r.val  = 64'(n);
            send(r, 1'b0, pbw_pkg::ERR_NONE);
            repeat (n)
            begin
                r      = junk_req();
                r.kind = pbw_pkg::REQ_RAW;
                send(r, 1'b0, pbw_pkg::ERR_NONE);
            end
        end
        else if (pick < 52)
        begin
            r.kind = pbw_pkg::REQ_START;
            r.fnum = pick_fnum();
            r.rsv  = coin(40) ? 3'd1 : 3'($urandom_range(7, 1));
            send(r, 1'b0, pbw_pkg::ERR_NONE);
        end
        else if (pick < 70)
        begin
            if (open_marks.size() != 0)
            begin
                r.kind = pbw_pkg::REQ_COMMIT;
                r.mark = open_marks.pop_back();
            end
            else
            begin
                r.kind = pbw_pkg::REQ_RAW;
            end
            send(r, 1'b0, pbw_pkg::ERR_NONE);
        end
        else
        begin
            case ($urandom_range(3))
                0: ;
                1:
                begin
                    // stale mark somewhere behind the offset, may be too short or empty
                    r.kind = pbw_pkg::REQ_COMMIT;
                    r.mark = {17'($urandom_range(int'(buf_offset))), 3'($urandom_range(7))};
                end
                2:
                begin
                    r.kind = pbw_pkg::REQ_BYTES;
                    r.val  = rand_bits(64) | 64'h1_0000;
                end
                default: r.kind = 3'($urandom_range(REQ_NONE_HI, REQ_NONE_LO));
            endcase
            send(r, 1'b0, pbw_pkg::ERR_NONE);
        end
    endtask

    task automatic check_write();
        buf_write_t w;
        if (due_writes.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%0t: result with no item pending: v=%b a=%h b=%h l=%b e=%0d",
                         $time, wr_valid, wr_addr, wr_byte, last, error);
            end
        end
        else
        begin
            w = due_writes.pop_front();
            writes_checked++;
            if (w.fin)
            begin
                err_seen[w.err]++;
            end
            if (wr_valid !== w.wv || wr_addr !== w.addr || wr_byte !== w.data ||
                last !== w.fin || mark_out !== w.mark || offset_out !== w.offset ||
                error !== w.err)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: mismatch exp v=%b a=%h b=%h l=%b m=%h o=%h e=%0d",
                             $time, w.wv, w.addr, w.data, w.fin, w.mark, w.offset, w.err);
                    $display("%0t:          got v=%b a=%h b=%h l=%b m=%h o=%h e=%0d",
                             $time, wr_valid, wr_addr, wr_byte, last, mark_out,
                             offset_out, error);
                end
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            check_write();
        end
        pop <= rst_n && !receiver_stalls();
    end

    initial
    begin
        int ph;
        int target;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // opening rows, offset starts at zero
        add_row(pbw_pkg::REQ_RAW,    29'd0,  64'd0,   8'hFF, 3'd0, '0,
                MK_LIT, 1'b0, pbw_pkg::ERR_NONE);
        add_row(pbw_pkg::REQ_VARINT, 29'd0,  64'd0,   8'h00, 3'd0, '0,
                MK_LIT, 1'b0, pbw_pkg::ERR_NONE);
        add_row(pbw_pkg::REQ_VARINT, FN_MAX, '1,      8'h00, 3'd0, '0,
                MK_LIT, 1'b0, pbw_pkg::ERR_NONE);
        add_row(pbw_pkg::REQ_BYTES,  29'd1,  64'd2,   8'h00, 3'd0, '0,
                MK_LIT, 1'b0, pbw_pkg::ERR_NONE);
        add_row(pbw_pkg::REQ_RAW,    29'd0,  64'd0,   8'h00, 3'd0, '0,
                MK_LIT, 1'b0, pbw_pkg::ERR_NONE);
        add_row(pbw_pkg::REQ_RAW,    29'd0,  64'd0,   8'hA5, 3'd0, '0,
                MK_LIT, 1'b0, pbw_pkg::ERR_NONE);
        add_row(pbw_pkg::REQ_BYTES,  FN_MAX, '1,      8'h00, 3'd0, '0,
                MK_LIT, 1'b1, pbw_pkg::ERR_FULL);
        add_row(pbw_pkg::REQ_START,  29'd2,  64'd0,   8'h00, 3'd0, '0,
                MK_LIT, 1'b1, pbw_pkg::ERR_TOO_LONG);
        add_row(pbw_pkg::REQ_START,  29'd2,  64'd0,   8'h00, 3'd7, '0,
                MK_LIT, 1'b0, pbw_pkg::ERR_NONE);
        add_row(pbw_pkg::REQ_VARINT, 29'd3,  64'd300, 8'h00, 3'd0, '0,
                MK_LIT, 1'b0, pbw_pkg::ERR_NONE);
        add_row(pbw_pkg::REQ_START,  FN_MAX, 64'd0,   8'h00, 3'd1, '0,
                MK_LIT, 1'b0, pbw_pkg::ERR_NONE);
        add_row(pbw_pkg::REQ_RAW,    29'd0,  64'd0,   8'h80, 3'd0, '0,
                MK_LIT, 1'b0, pbw_pkg::ERR_NONE);
        add_row(pbw_pkg::REQ_COMMIT, 29'd0,  64'd0,   8'h00, 3'd0, '0,
                MK_LAST, 1'b0, pbw_pkg::ERR_NONE);
        add_row(pbw_pkg::REQ_COMMIT, 29'd0,  64'd0,   8'h00, 3'd0, '0,
                MK_LAST, 1'b0, pbw_pkg::ERR_NONE);
        add_row(pbw_pkg::REQ_COMMIT, 29'd0,  64'd0,   8'h00, 3'd0, '0,
                MK_LIT, 1'b1, pbw_pkg::ERR_BAD_MARK);
        add_row(pbw_pkg::REQ_COMMIT, 29'd0,  64'd0,   8'h00, 3'd1, '0,
                MK_HERE, 1'b1, pbw_pkg::ERR_BAD_MARK);
        add_row(pbw_pkg::REQ_COMMIT, 29'd0,  64'd0,   8'h00, 3'd0, 20'h00001,
                MK_LIT, 1'b0, pbw_pkg::ERR_NONE);
        add_row(REQ_NONE_LO,         FN_MAX, '1,      8'hFF, 3'd7, '1,
                MK_LIT, 1'b1, pbw_pkg::ERR_NONE);
        walk_rows();

        for (ph = 0; ph < 4; ph++)
        begin
            idle_mode = idle_mode_e'(ph);
            target    = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target)
            begin
                random_step();
            end
        end

        // closing rows with both sides idling
        idle_mode = IDLE_BOTH;
        add_row(pbw_pkg::REQ_RAW,    29'd0,  64'd0,   8'h5A, 3'd0, '0,
                MK_LIT, 1'b0, pbw_pkg::ERR_NONE);
        add_row(pbw_pkg::REQ_BYTES,  FN_MAX, '1,      8'h00, 3'd0, '0,
                MK_LIT, 1'b1, pbw_pkg::ERR_FULL);
        add_row(pbw_pkg::REQ_START,  29'd1,  64'd0,   8'h00, 3'd0, '0,
                MK_LIT, 1'b1, pbw_pkg::ERR_TOO_LONG);
        add_row(pbw_pkg::REQ_COMMIT, 29'd0,  64'd0,   8'h00, 3'd0, '0,
                MK_LAST, 1'b0, pbw_pkg::ERR_NONE);
        add_row(pbw_pkg::REQ_COMMIT, 29'd0,  64'd0,   8'h00, 3'd0, 20'h00001,
                MK_LIT, 1'b0, pbw_pkg::ERR_NONE);
        add_row(pbw_pkg::REQ_COMMIT, 29'd0,  64'd0,   8'h00, 3'd1, '0,
                MK_HERE, 1'b1, pbw_pkg::ERR_BAD_MARK);
        add_row(REQ_NONE_HI,         29'd0,  64'd0,   8'h00, 3'd0, '0,
                MK_LIT, 1'b1, pbw_pkg::ERR_NONE);
        walk_rows();
        push <= 1'b0;

        idle_mode = IDLE_NONE;
        while (due_writes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);

        $display("sent %0d items, checked %0d results, final offset %0d of %0d",
                 items_sent, writes_checked, buf_offset, pbw_pkg::BUF_BYTES);
        $display("rejections seen: buffer full %0d, length too long %0d, bad mark %0d",
                 err_seen[pbw_pkg::ERR_FULL], err_seen[pbw_pkg::ERR_TOO_LONG],
                 err_seen[pbw_pkg::ERR_BAD_MARK]);
        if (mismatches == 0)
        begin
            $display("protobuf_wire_encoder test passed");
        end
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("protobuf_wire_encoder test failed");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #(64'd5_000_000);
        $display("timeout with %0d results still due", due_writes.size());
        $display("protobuf_wire_encoder test failed");
        $finish;
    end

endmodule
